@@ src/japanese_charset_detector_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Japanese charset detector
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef JAPANESE_CHARSET_DETECTOR_TOP_ASSERT_SVH
`define JAPANESE_CHARSET_DETECTOR_TOP_ASSERT_SVH

// Check a property on every aclk edge outside reset.
`define JCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every aclk edge, reset included.
`define JCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/jcd_pkg.sv @@
// ----------------------------------------------------------------------------
// jcd_pkg
// Shared types, codes and the per-position scanner step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jcd_pkg;

    localparam int CNT_W = 12;
    localparam int PROD_W = 20;
    localparam int DEF_SAMPLE_LIMIT = 1000;

    localparam logic [1:0] ST_SCAN = 2'd0;
    localparam logic [1:0] ST_YES  = 2'd1;
    localparam logic [1:0] ST_NO   = 2'd2;

    localparam logic [2:0] ENC_UCS2 = 3'd0;
    localparam logic [2:0] ENC_EUC  = 3'd1;
    localparam logic [2:0] ENC_ISO  = 3'd2;
    localparam logic [2:0] ENC_UTF8 = 3'd3;
    localparam logic [2:0] ENC_SJIS = 3'd4;

    typedef logic [5:0][7:0] win_t;

    typedef struct packed {
        logic [CNT_W-1:0] zhi;
        logic [CNT_W-1:0] zlo;
        logic [CNT_W-1:0] euc;
        logic [CNT_W-1:0] sjis;
        logic [1:0]       st_euc;
        logic [1:0]       st_utf;
        logic [1:0]       st_sjis;
        logic [1:0]       sk_euc;
        logic [1:0]       sk_utf;
        logic [1:0]       sk_sjis;
        logic             esc;
    } scan_st_t;

    typedef struct packed {
        scan_st_t         st;
        logic [CNT_W-1:0] len;
        logic [15:0]      ftb;
    } dec_in_t;

    function automatic logic is_cont(logic [7:0] v);
        return v[7:6] == 2'b10;
    endfunction

    // One scanner step at sample position i; w[0] holds byte i.
    function automatic scan_st_t jcd_scan(scan_st_t st, win_t w, logic [CNT_W-1:0] i,
                                          logic [CNT_W-1:0] len, logic no_end,
                                          logic [CNT_W-1:0] utf_lim);
        scan_st_t n;
        logic [7:0] c0, c1, c2, c3, c4, c5;
        logic hit;
        n = st;
        c0 = w[0]; c1 = w[1]; c2 = w[2]; c3 = w[3]; c4 = w[4]; c5 = w[5];

        if (!i[0] && (no_end || (i + 1'b1) < len)) begin
            if (c0 == 8'h00) begin
                n.zhi = st.zhi + 1'b1;
            end else if (c1 == 8'h00) begin
                n.zlo = st.zlo + 1'b1;
            end
        end

        if (st.st_euc == ST_SCAN) begin
            if (st.sk_euc != 2'd0) begin
                n.sk_euc = st.sk_euc - 1'b1;
            end else if (c0 inside {[8'h21:8'h7E], 8'h0A, 8'h0D}) begin
                n.euc = st.euc + 1'b1;
            end else if (c0 >= 8'hA1 && c1 >= 8'hA1) begin
                n.euc = st.euc + CNT_W'(2);
                n.sk_euc = 2'd1;
            end else if (c0 == 8'h8E && c1 inside {[8'hA1:8'hDF]}) begin
                n.euc = st.euc + CNT_W'(2);
                n.sk_euc = 2'd1;
            end else if (c0 == 8'h8F && c1 inside {[8'hA1:8'hDF]}
                         && c2 inside {[8'hA1:8'hDF]}) begin
                n.euc = st.euc + CNT_W'(3);
                n.sk_euc = 2'd2;
            end else begin
                n.st_euc = ST_NO;
            end
        end

        hit = (c1 == 8'h24 && (c2 == 8'h40 || c2 == 8'h42)) ||
              (c1 == 8'h28 && (c2 == 8'h4A || c2 == 8'h48 || c2 == 8'h42 || c2 == 8'h49)) ||
              (c1 == 8'h26 && c2 == 8'h40 && c3 == 8'h1B && c4 == 8'h24 && c5 == 8'h42) ||
              (c1 == 8'h24 && c2 == 8'h28 && c3 == 8'h44) ||
              c1 == 8'h42 || c1 == 8'h40;
        if (!st.esc && c0 == 8'h1B && hit) begin
            n.esc = 1'b1;
        end

        if (st.st_utf == ST_SCAN) begin
            if (st.sk_utf != 2'd0) begin
                n.sk_utf = st.sk_utf - 1'b1;
            end else if (c0[7:5] == 3'b110 && is_cont(c1)) begin
                n.sk_utf = 2'd1;
            end else if (c0[7:4] == 4'b1110 && is_cont(c1) && is_cont(c2)) begin
                n.sk_utf = 2'd2;
            end else if (c0[7:3] == 5'b11110 && is_cont(c1) && is_cont(c2) && is_cont(c3)) begin
                n.sk_utf = 2'd3;
            end else if (!c0[7] || i >= utf_lim) begin
                n.sk_utf = 2'd0;
            end else begin
                n.st_utf = ST_NO;
            end
        end

        if (st.st_sjis == ST_SCAN) begin
            if (st.sk_sjis != 2'd0) begin
                n.sk_sjis = st.sk_sjis - 1'b1;
            end else if (c0 inside {[8'h81:8'h9F]} && c1 inside {[8'h40:8'hFC]}) begin
                if (c0 == 8'h8E && c1 inside {[8'hA1:8'hDF]}) begin
                    n.sjis = st.sjis + CNT_W'(2);
                    n.sk_sjis = 2'd1;
                end else if (c0 == 8'h8F && c1 inside {[8'hA1:8'hDF]}
                             && c2 inside {[8'hA1:8'hDF]}) begin
                    n.sjis = st.sjis + CNT_W'(3);
                    n.sk_sjis = 2'd2;
                end else begin
                    n.st_sjis = ST_YES;
                end
            end else if (c0 inside {[8'hE0:8'hEF]}) begin
                if (c1 inside {[8'h40:8'h7E]}) begin
                    n.st_sjis = ST_YES;
                end else if (c1 inside {[8'h80:8'hFC]}) begin
                    n.sjis = st.sjis + CNT_W'(2);
                    n.sk_sjis = 2'd1;
                end
            end else if (c0 inside {[8'hA1:8'hDF], [8'h20:8'h7E], 8'h0A, 8'h0D}) begin
                n.sjis = st.sjis + 1'b1;
            end else begin
                n.sjis = '0;
                n.st_sjis = ST_NO;
            end
        end
        return n;
    endfunction

endpackage

@@ src/jcd_decide.sv @@
// ----------------------------------------------------------------------------
// jcd_decide
// Holds the final scanner state of a text, picks the encoding and byte order,
// and presents the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcd_decide import jcd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dec_in_t    in_data,
    input  logic       default_big_endian,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic       dec_valid_reg, dec_valid_next;
    dec_in_t    dec_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_adv, dec_adv;

    logic [CNT_W:0]    conf;
    logic              cbe;
    logic [PROD_W-1:0] conf_x100, len_x98;
    logic [2:0]        enc;
    logic              be;

    assign out_adv  = !out_valid_reg || m_tready;
    assign dec_adv  = !dec_valid_reg || out_adv;
    assign in_ready = dec_adv;

    always_comb begin
        if (dec_reg.st.zhi > dec_reg.st.zlo) begin
            conf = {dec_reg.st.zhi, 1'b0};
            cbe = 1'b1;
        end else begin
            conf = {dec_reg.st.zlo, 1'b0};
            cbe = 1'b0;
        end
        conf_x100 = PROD_W'(conf) * PROD_W'(100);
        len_x98 = PROD_W'(dec_reg.len) * PROD_W'(98);

        enc = ENC_UCS2;
        be = default_big_endian;
        if (dec_reg.len >= CNT_W'(2) && dec_reg.ftb == 16'hFFFE) begin
            be = 1'b0;
        end else if (dec_reg.len >= CNT_W'(2) && dec_reg.ftb == 16'hFEFF) begin
            be = 1'b1;
        end else if (conf_x100 >= len_x98) begin
            be = cbe;
        end else if (dec_reg.st.st_euc != ST_NO && dec_reg.st.euc == dec_reg.len) begin
            enc = ENC_EUC;
        end else if (dec_reg.st.esc) begin
            enc = ENC_ISO;
        end else if (dec_reg.st.st_utf != ST_NO) begin
            enc = ENC_UTF8;
        end else if (dec_reg.st.st_sjis == ST_YES ||
                     (dec_reg.st.st_sjis == ST_SCAN && dec_reg.st.sjis == dec_reg.len)) begin
            enc = ENC_SJIS;
        end else if (dec_reg.st.sjis > dec_reg.st.euc
                     && {dec_reg.st.sjis, 1'b0} > {1'b0, dec_reg.len}) begin
            enc = ENC_SJIS;
        end else if (dec_reg.st.euc > dec_reg.st.sjis
                     && {dec_reg.st.euc, 1'b0} > {1'b0, dec_reg.len}) begin
            enc = ENC_EUC;
        end
    end

    always_comb begin
        dec_valid_next = dec_adv ? in_valid : dec_valid_reg;
        out_valid_next = out_adv ? dec_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            dec_valid_reg <= dec_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_adv && in_valid) begin
            dec_reg <= in_data;
        end
        if (out_adv && dec_valid_reg) begin
            out_data_reg <= {4'b0, be, enc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ src/japanese_charset_detector_top.sv @@
// Result path: last byte -> input register -> decision register -> output register.
// Throughput: one byte per cycle unless stalled; per-byte scanners and five-position
//   flush at the last byte all settle in the single stage after the input register.
// Reset: aresetn is synchronous, active low; it empties the pipeline, clears the
//   stream state and sets default_big_endian to 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
// japanese_charset_detector_top
// Streams text bytes through five encoding scanners (UCS-2, EUC-JP,
// ISO-2022-JP, UTF-8, Shift-JIS) and reports one encoding per text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module japanese_charset_detector_top import jcd_pkg::*; #(
    parameter int SAMPLE_LIMIT = DEF_SAMPLE_LIMIT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // default_big_endian
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] data_byte
    input  logic       s_tlast,       // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata        // [2:0] encoding, [3] big_endian, [7:4] zero
);

    localparam logic [CNT_W-1:0] LIMIT   = CNT_W'(SAMPLE_LIMIT);
    localparam logic [CNT_W-1:0] UTF_LIM = CNT_W'(SAMPLE_LIMIT - 2);

    // Default byte order register.
    logic dflt_be_reg;

    // Input register: one byte transfer waits here for the scanners.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Stream state of the text in flight.
    win_t             win_reg, win_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [15:0]      ftb_reg, ftb_next;
    scan_st_t         st_reg, st_next;

    // Final state handed to the decision stage.
    dec_in_t dec_data;
    logic    dec_ready;
    logic    consume;

    // Working values of the flush chain.
    scan_st_t         st_w;
    win_t             win_w;
    logic [CNT_W-1:0] pos_w, fpos;

    // Retire the held byte unless it closes a text and the decision stage is full.
    assign consume  = in_valid_reg && (!in_last_reg || dec_ready);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_be_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            dflt_be_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Scan one byte, and at the last byte drain the window with zeros.
    always_comb begin
        st_w  = st_reg;
        win_w = win_reg;
        pos_w = pos_reg;
        fpos  = '0;
        ftb_next = ftb_reg;

        // Take the byte only while the sample is still open.
        if (pos_reg < LIMIT) begin
            if (pos_reg == CNT_W'(0)) begin
                ftb_next = {in_byte_reg, 8'h00};
            end else if (pos_reg == CNT_W'(1)) begin
                ftb_next = {ftb_reg[15:8], in_byte_reg};
            end
            win_w = {in_byte_reg, win_reg[5:1]};
            if (pos_reg >= CNT_W'(5)) begin
                st_w = jcd_scan(st_w, win_w, pos_reg - CNT_W'(5), '0, 1'b1, UTF_LIM);
            end
            pos_w = pos_reg + 1'b1;
        end

        dec_data.ftb = ftb_next;
        dec_data.len = pos_w;

        // Flush: advance five zero bytes so the trailing positions get scanned.
        if (in_last_reg) begin
            for (int s = 1; s <= 5; s++) begin
                fpos  = pos_w + CNT_W'(s);
                win_w = {8'h00, win_w[5:1]};
                if (fpos >= CNT_W'(6)) begin
                    st_w = jcd_scan(st_w, win_w, fpos - CNT_W'(6), pos_w, 1'b0, UTF_LIM);
                end
            end
        end
        dec_data.st = st_w;

        // Hold when nothing retires; clear for the next text after a last byte.
        if (!consume) begin
            st_next  = st_reg;
            win_next = win_reg;
            pos_next = pos_reg;
            ftb_next = ftb_reg;
        end else if (in_last_reg) begin
            st_next  = '0;
            win_next = '0;
            pos_next = '0;
            ftb_next = '0;
        end else begin
            st_next  = st_w;
            win_next = win_w;
            pos_next = pos_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            win_reg <= '0;
            pos_reg <= '0;
            ftb_reg <= '0;
        end else begin
            st_reg  <= st_next;
            win_reg <= win_next;
            pos_reg <= pos_next;
            ftb_reg <= ftb_next;
        end
    end

    jcd_decide u_decide (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (in_valid_reg && in_last_reg),
        .in_ready           (dec_ready),
        .in_data            (dec_data),
        .default_big_endian (dflt_be_reg),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata)
    );

endmodule

@@ src/jcd_checker.sv @@
// ----------------------------------------------------------------------------
// jcd_checker
// Port-level checks on the result channel of the detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "japanese_charset_detector_top_assert.svh"

module jcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `JCD_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `JCD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result present after reset")
    `JCD_ASSERT(a_enc_range, m_tvalid |-> m_tdata[2:0] <= 3'd4, "encoding code out of range")
    `JCD_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[7:4] == 4'd0, "result padding not zero")

endmodule

bind japanese_charset_detector_top jcd_checker u_jcd_checker (.*);
